>>> src/tfs_pkg.sv
`default_nettype none

package tfs_pkg;

  typedef enum logic [1:0] {
    ACT_TICK     = 2'd0,
    ACT_ATTACH   = 2'd1,
    ACT_WRITE    = 2'd2,
    ACT_SOFT_RST = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    CMD_NONE   = 2'd0,
    CMD_ECHO   = 2'd1,
    CMD_UNLOCK = 2'd2,
    CMD_GET    = 2'd3
  } cmd_t;

  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PACE        = 3'd0,
    REG_UNLOCK_WAIT = 3'd1,
    REG_RESEND      = 3'd2,
    REG_POLL_BASE   = 3'd3,
    REG_POLL_STEP   = 3'd4,
    REG_REFETCH     = 3'd5
  } cfg_idx_t;

  localparam logic [31:0] PACE_RST        = 32'd80000;
  localparam logic [31:0] UNLOCK_WAIT_RST = 32'd4000000;
  localparam logic [31:0] RESEND_RST      = 32'd500000;
  localparam logic [31:0] POLL_BASE_RST   = 32'd1000000;
  localparam logic [31:0] POLL_STEP_RST   = 32'd250000;
  localparam logic [31:0] REFETCH_RST     = 32'd5500000;

  localparam logic [7:0] FIRST_PROFILE = 8'h70;
  localparam logic [7:0] LAST_PROFILE  = 8'h7B;
  localparam logic [7:0] POLL_REPORT   = 8'h81;
  localparam logic [7:0] SAVE_ID_LO    = 8'h60;
  localparam logic [7:0] SAVE_ID_HI    = 8'h62;
  localparam logic [7:0] NO_REPORT     = 8'h00;

  // post-save chain steps
  localparam logic [3:0] PS_RESEND     = 4'd0;
  localparam logic [3:0] PS_POLL_FIRST = 4'd1;
  localparam logic [3:0] PS_POLL_LAST  = 4'd6;
  localparam logic [3:0] PS_REFETCH    = 4'd7;
  localparam logic [3:0] PS_DONE       = 4'd8;

  typedef struct packed {
    logic [31:0] pace_interval_us;
    logic [31:0] unlock_wait_us;
    logic [31:0] resend_delay_us;
    logic [31:0] poll_base_us;
    logic [31:0] poll_step_us;
    logic [31:0] refetch_delay_us;
  } cfg_regs_t;

  typedef struct packed {
    action_t     action;
    logic [31:0] now_us;
    logic        connected;
    logic        firmware_cached;
    logic [7:0]  write_id;
  } item_t;

  typedef struct packed {
    logic        unlock_waiting;
    logic [31:0] unlock_start_time;
    logic        ready_flag;
    logic        post_save_active;
    logic [31:0] write_time;
    logic [3:0]  post_save_step;
    logic [7:0]  next_fetch_report;
    logic [31:0] last_fetch_time;
    logic        mark_ready_when_done;
  } seq_state_t;

  typedef struct packed {
    logic       two;
    cmd_t       cmd0;
    logic [7:0] rep0;
    cmd_t       cmd1;
    logic [7:0] rep1;
    logic       ready;
  } step_res_t;

  function automatic seq_state_t state_reset();
    seq_state_t s;
    s.unlock_waiting       = 1'b0;
    s.unlock_start_time    = 32'd0;
    s.ready_flag           = 1'b1;
    s.post_save_active     = 1'b0;
    s.write_time           = 32'd0;
    s.post_save_step       = PS_RESEND;
    s.next_fetch_report    = NO_REPORT;
    s.last_fetch_time      = 32'd0;
    s.mark_ready_when_done = 1'b0;
    return s;
  endfunction

endpackage

`default_nettype wire

>>> src/timed_report_fetch_sequencer_core.sv
`default_nettype none

// Timed report fetch sequencer. Each input beat (tick, attach, profile write
// or soft reset) yields one or two result beats with the command to issue,
// the report to fetch, the snapshot-ready flag and a last marker. A beat is
// held in an input register and processed into a two-entry result buffer;
// beats are never processed back to back, because the registered
// status-poll threshold (base plus step times poll count) is refreshed in
// the cycle after every state update or register write. A held beat waits
// while the result buffer cannot take its results. Configuration writes are
// always ready.
module timed_report_fetch_sequencer_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [1:0]                    in_action,
  input  wire logic [31:0]                   in_now_us,
  input  wire logic                          in_connected,
  input  wire logic                          in_firmware_cached,
  input  wire logic [7:0]                    in_write_id,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [1:0]                         out_command,
  output logic [7:0]                         out_command_report,
  output logic                               out_snap_ready,
  output logic                               out_last,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [tfs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]                   cfg_data
);
  import tfs_pkg::*;

  cfg_regs_t  regs;
  logic       cfg_we;
  item_t      item_r;
  logic       in_full_r;
  logic       settle_r;
  seq_state_t st_r;
  seq_state_t st_nxt;
  step_res_t  res;
  logic       can_push;
  logic       commit;

  tfs_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .regs      (regs),
    .wr_en     (cfg_we)
  );

  assign commit   = in_full_r && !settle_r && can_push;
  assign in_ready = !in_full_r || commit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_full_r <= 1'b0;
      settle_r  <= 1'b0;
      st_r      <= state_reset();
    end else begin
      settle_r <= commit || cfg_we;
      if (in_valid && in_ready) begin
        in_full_r <= 1'b1;
      end else if (commit) begin
        in_full_r <= 1'b0;
      end
      if (commit) begin
        st_r <= st_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.action          <= action_t'(in_action);
      item_r.now_us          <= in_now_us;
      item_r.connected       <= in_connected;
      item_r.firmware_cached <= in_firmware_cached;
      item_r.write_id        <= in_write_id;
    end
  end

  tfs_step u_step (
    .clk    (clk),
    .regs   (regs),
    .st     (st_r),
    .item   (item_r),
    .st_nxt (st_nxt),
    .res    (res)
  );

  tfs_outq u_outq (
    .clk                (clk),
    .rst_n              (rst_n),
    .push               (commit),
    .res                (res),
    .can_push           (can_push),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_command        (out_command),
    .out_command_report (out_command_report),
    .out_snap_ready     (out_snap_ready),
    .out_last           (out_last)
  );

`ifndef NO_ASSERTIONS
  a_commit_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> !commit)
    else $error("beats processed in adjacent cycles");

  a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> out_valid)
    else $error("processed beat left no result");

  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    (commit && res.two) |=> (out_valid && !out_last))
    else $error("first of two results marked last");
`endif

endmodule

`default_nettype wire

>>> src/tfs_cfg.sv
`default_nettype none

module tfs_cfg (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [tfs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]                   cfg_data,
  output tfs_pkg::cfg_regs_t                 regs,
  output logic                               wr_en
);
  import tfs_pkg::*;

  cfg_regs_t regs_r;

  assign cfg_ready = 1'b1;
  assign wr_en     = cfg_valid && cfg_ready;
  assign regs      = regs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.pace_interval_us <= PACE_RST;
      regs_r.unlock_wait_us   <= UNLOCK_WAIT_RST;
      regs_r.resend_delay_us  <= RESEND_RST;
      regs_r.poll_base_us     <= POLL_BASE_RST;
      regs_r.poll_step_us     <= POLL_STEP_RST;
      regs_r.refetch_delay_us <= REFETCH_RST;
    end else if (wr_en) begin
      unique case (cfg_index)
        REG_PACE:        regs_r.pace_interval_us <= cfg_data;
        REG_UNLOCK_WAIT: regs_r.unlock_wait_us   <= cfg_data;
        REG_RESEND:      regs_r.resend_delay_us  <= cfg_data;
        REG_POLL_BASE:   regs_r.poll_base_us     <= cfg_data;
        REG_POLL_STEP:   regs_r.poll_step_us     <= cfg_data;
        REG_REFETCH:     regs_r.refetch_delay_us <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> src/tfs_step.sv
`default_nettype none

module tfs_step (
  input  wire logic                clk,
  input  wire tfs_pkg::cfg_regs_t  regs,
  input  wire tfs_pkg::seq_state_t st,
  input  wire tfs_pkg::item_t      item,
  output tfs_pkg::seq_state_t      st_nxt,
  output tfs_pkg::step_res_t       res
);
  import tfs_pkg::*;

  logic [31:0] poll_thr_r;
  logic [31:0] poll_thr_nxt;
  logic [2:0]  poll_k;
  logic [31:0] fetch_since;
  logic [31:0] save_since;
  logic [31:0] unlock_since;
  logic        skip;
  logic        got_fetch;
  cmd_t        ps_cmd;
  logic [7:0]  ps_rep;
  seq_state_t  s;
  step_res_t   r;

  // registered threshold of the current status poll, computed from the held state
  assign poll_k       = st.post_save_step[2:0] - 3'd1;
  assign poll_thr_nxt = regs.poll_base_us + regs.poll_step_us * {29'd0, poll_k};

  always_ff @(posedge clk) begin
    poll_thr_r <= poll_thr_nxt;
  end

  assign fetch_since  = item.now_us - st.last_fetch_time;
  assign save_since   = item.now_us - st.write_time;
  assign unlock_since = item.now_us - st.unlock_start_time;

  always_comb begin
    s         = st;
    r.two     = 1'b0;
    r.cmd0    = CMD_NONE;
    r.rep0    = NO_REPORT;
    r.cmd1    = CMD_NONE;
    r.rep1    = NO_REPORT;
    skip      = 1'b0;
    got_fetch = 1'b0;
    ps_cmd    = CMD_NONE;
    ps_rep    = NO_REPORT;
    unique case (item.action)
      ACT_TICK: begin
        if (st.next_fetch_report != NO_REPORT) begin
          if (!item.connected) begin
            s.next_fetch_report    = NO_REPORT;
            s.mark_ready_when_done = 1'b0;
            skip                   = 1'b1;
          end else if (fetch_since >= regs.pace_interval_us) begin
            s.last_fetch_time = item.now_us;
            r.cmd0            = CMD_GET;
            r.rep0            = st.next_fetch_report;
            got_fetch         = 1'b1;
            if (st.next_fetch_report == LAST_PROFILE) begin
              s.next_fetch_report = NO_REPORT;
              if (st.mark_ready_when_done) begin
                s.mark_ready_when_done = 1'b0;
                s.ready_flag           = 1'b1;
              end
            end else begin
              s.next_fetch_report = st.next_fetch_report + 8'd1;
            end
          end
        end
        if (!skip && st.post_save_active) begin
          if (!item.connected) begin
            s.post_save_active = 1'b0;
            s.write_time       = 32'd0;
            s.post_save_step   = PS_RESEND;
            skip               = 1'b1;
          end else if (st.post_save_step == PS_RESEND &&
                       save_since >= regs.resend_delay_us) begin
            ps_cmd           = CMD_UNLOCK;
            s.post_save_step = PS_POLL_FIRST;
          end else if (st.post_save_step >= PS_POLL_FIRST &&
                       st.post_save_step <= PS_POLL_LAST &&
                       save_since >= poll_thr_r) begin
            ps_cmd           = CMD_GET;
            ps_rep           = POLL_REPORT;
            s.post_save_step = st.post_save_step + 4'd1;
          end else if (st.post_save_step == PS_REFETCH &&
                       save_since >= regs.refetch_delay_us) begin
            s.next_fetch_report    = FIRST_PROFILE;
            s.last_fetch_time      = 32'd0;
            s.mark_ready_when_done = 1'b0;
            s.post_save_step       = PS_DONE;
            s.post_save_active     = 1'b0;
            s.write_time           = 32'd0;
          end
          if (ps_cmd != CMD_NONE) begin
            if (got_fetch) begin
              r.cmd1 = ps_cmd;
              r.rep1 = ps_rep;
              r.two  = 1'b1;
            end else begin
              r.cmd0 = ps_cmd;
              r.rep0 = ps_rep;
            end
          end
        end
        if (!skip && st.unlock_waiting) begin
          if (!item.connected) begin
            s.unlock_waiting = 1'b0;
            s.ready_flag     = 1'b1;
          end else if (unlock_since >= regs.unlock_wait_us) begin
            s.next_fetch_report    = FIRST_PROFILE;
            s.last_fetch_time      = 32'd0;
            s.mark_ready_when_done = 1'b1;
            s.unlock_waiting       = 1'b0;
          end
        end
      end
      ACT_ATTACH: begin
        if (item.firmware_cached) begin
          r.cmd0 = CMD_ECHO;
          r.cmd1 = CMD_UNLOCK;
          r.two  = 1'b1;
        end else begin
          r.cmd0 = CMD_UNLOCK;
        end
        s.unlock_start_time = item.now_us;
        s.unlock_waiting    = 1'b1;
        s.ready_flag        = 1'b0;
      end
      ACT_WRITE: begin
        if (item.write_id >= SAVE_ID_LO && item.write_id <= SAVE_ID_HI) begin
          s.write_time       = item.now_us;
          s.post_save_step   = PS_RESEND;
          s.post_save_active = 1'b1;
        end
      end
      ACT_SOFT_RST: begin
        s = state_reset();
      end
      default: ;
    endcase
    r.ready = s.ready_flag;
  end

  assign st_nxt = s;
  assign res    = r;

endmodule

`default_nettype wire

>>> src/tfs_outq.sv
`default_nettype none

module tfs_outq (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  input  wire tfs_pkg::step_res_t  res,
  output logic                     can_push,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [1:0]               out_command,
  output logic [7:0]               out_command_report,
  output logic                     out_snap_ready,
  output logic                     out_last
);
  import tfs_pkg::*;

  logic [1:0] cnt_r;
  cmd_t       cmd0_r;
  logic [7:0] rep0_r;
  logic       last0_r;
  cmd_t       cmd1_r;
  logic [7:0] rep1_r;
  logic       ready_r;
  logic       pop;

  assign out_valid = cnt_r != 2'd0;
  assign pop       = out_valid && out_ready;
  // a push lands only when the buffer is empty or drains this cycle
  assign can_push  = (cnt_r == 2'd0) || (cnt_r == 2'd1 && out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else if (push) begin
      cnt_r <= res.two ? 2'd2 : 2'd1;
    end else if (pop) begin
      cnt_r <= cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      cmd0_r  <= res.cmd0;
      rep0_r  <= res.rep0;
      last0_r <= !res.two;
      cmd1_r  <= res.cmd1;
      rep1_r  <= res.rep1;
      ready_r <= res.ready;
    end else if (pop) begin
      cmd0_r  <= cmd1_r;
      rep0_r  <= rep1_r;
      last0_r <= 1'b1;
    end
  end

  assign out_command        = cmd0_r;
  assign out_command_report = rep0_r;
  assign out_snap_ready     = ready_r;
  assign out_last           = last0_r;

endmodule

`default_nettype wire

>>> sim/tfs_checker.sv
`timescale 1ns / 1ps

module tfs_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic [1:0]                    in_action,
  input  logic [31:0]                   in_now_us,
  input  logic                          in_connected,
  input  logic                          in_firmware_cached,
  input  logic [7:0]                    in_write_id,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [1:0]                    out_command,
  input  logic [7:0]                    out_command_report,
  input  logic                          out_snap_ready,
  input  logic                          out_last,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [tfs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data,
  output int                            fail_count,
  output int                            pending
);
  import tfs_pkg::*;

  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] rep;
    logic       ready;
    logic       last;
  } cmd_beat_t;

  cmd_beat_t  due_cmds[$];
  seq_state_t st;
  cfg_regs_t  regs;
  cmd_t       step_cmd[2];
  logic [7:0] step_rep[2];
  int         step_n;
  int         n_fail = 0;
  int         n_due = 0;

  assign fail_count = n_fail;
  assign pending    = n_due;

  task automatic report(input string msg);
    $display("tfs_checker: %0t: %s", $realtime, msg);
    n_fail++;
  endtask

  task automatic clear_seq();
    st.unlock_waiting       = 1'b0;
    st.unlock_start_time    = 32'd0;
    st.ready_flag           = 1'b1;
    st.post_save_active     = 1'b0;
    st.write_time           = 32'd0;
    st.post_save_step       = PS_RESEND;
    st.next_fetch_report    = NO_REPORT;
    st.last_fetch_time      = 32'd0;
    st.mark_ready_when_done = 1'b0;
  endtask

  task automatic add_cmd(input cmd_t c, input logic [7:0] r);
    if (step_n < 2) begin
      step_cmd[step_n] = c;
      step_rep[step_n] = r;
      step_n++;
    end
  endtask

  task automatic begin_fetch(input logic mark);
    st.next_fetch_report    = FIRST_PROFILE;
    st.last_fetch_time      = 32'd0;
    st.mark_ready_when_done = mark;
  endtask

  task automatic serve_tick(input logic [31:0] now, input logic conn);
    logic [31:0] since;
    logic [31:0] poll_at;
    if (st.next_fetch_report != NO_REPORT) begin
      if (!conn) begin
        st.next_fetch_report    = NO_REPORT;
        st.mark_ready_when_done = 1'b0;
        return;
      end
      if (now - st.last_fetch_time >= regs.pace_interval_us) begin
        st.last_fetch_time = now;
        add_cmd(CMD_GET, st.next_fetch_report);
        if (st.next_fetch_report == LAST_PROFILE) begin
          st.next_fetch_report = NO_REPORT;
          if (st.mark_ready_when_done) begin
            st.mark_ready_when_done = 1'b0;
            st.ready_flag = 1'b1;
          end
        end else begin
          st.next_fetch_report = st.next_fetch_report + 8'd1;
        end
      end
    end
    if (st.post_save_active) begin
      if (!conn) begin
        st.post_save_active = 1'b0;
        st.write_time       = 32'd0;
        st.post_save_step   = PS_RESEND;
        return;
      end
      since   = now - st.write_time;
      poll_at = regs.poll_base_us + regs.poll_step_us * 32'(st.post_save_step - PS_POLL_FIRST);
      if (st.post_save_step == PS_RESEND && since >= regs.resend_delay_us) begin
        add_cmd(CMD_UNLOCK, NO_REPORT);
        st.post_save_step = PS_POLL_FIRST;
      end else if (st.post_save_step >= PS_POLL_FIRST && st.post_save_step <= PS_POLL_LAST &&
                   since >= poll_at) begin
        add_cmd(CMD_GET, POLL_REPORT);
        st.post_save_step = st.post_save_step + 4'd1;
      end else if (st.post_save_step == PS_REFETCH && since >= regs.refetch_delay_us) begin
        begin_fetch(1'b0);
        st.post_save_step   = PS_DONE;
        st.post_save_active = 1'b0;
        st.write_time       = 32'd0;
      end
    end
    if (!st.unlock_waiting) return;
    if (!conn) begin
      st.unlock_waiting = 1'b0;
      st.ready_flag     = 1'b1;
      return;
    end
    if (now - st.unlock_start_time >= regs.unlock_wait_us) begin
      begin_fetch(1'b1);
      st.unlock_waiting = 1'b0;
    end
  endtask

  task automatic predict_step(input item_t ev);
    cmd_beat_t b;
    step_n = 0;
    case (ev.action)
      ACT_TICK: serve_tick(ev.now_us, ev.connected);
      ACT_ATTACH: begin
        if (ev.firmware_cached) add_cmd(CMD_ECHO, NO_REPORT);
        add_cmd(CMD_UNLOCK, NO_REPORT);
        st.unlock_start_time = ev.now_us;
        st.unlock_waiting    = 1'b1;
        st.ready_flag        = 1'b0;
      end
      ACT_WRITE: begin
        if (ev.write_id >= SAVE_ID_LO && ev.write_id <= SAVE_ID_HI) begin
          st.write_time       = ev.now_us;
          st.post_save_step   = PS_RESEND;
          st.post_save_active = 1'b1;
        end
      end
      default: clear_seq();
    endcase
    if (step_n == 0) add_cmd(CMD_NONE, NO_REPORT);
    for (int k = 0; k < step_n; k++) begin
      b.cmd   = step_cmd[k];
      b.rep   = step_rep[k];
      b.ready = st.ready_flag;
      b.last  = (k == step_n - 1);
      due_cmds.push_back(b);
    end
  endtask

  task automatic set_reg(input cfg_idx_t idx, input logic [31:0] val);
    case (idx)
      REG_PACE:        regs.pace_interval_us = val;
      REG_UNLOCK_WAIT: regs.unlock_wait_us   = val;
      REG_RESEND:      regs.resend_delay_us  = val;
      REG_POLL_BASE:   regs.poll_base_us     = val;
      REG_POLL_STEP:   regs.poll_step_us     = val;
      REG_REFETCH:     regs.refetch_delay_us = val;
      default: ;
    endcase
  endtask

  task automatic check_beat();
    cmd_beat_t want;
    if (due_cmds.size() == 0) begin
      report($sformatf("beat with nothing expected: cmd %0d rep %02h",
                       out_command, out_command_report));
      return;
    end
    want = due_cmds.pop_front();
    if (out_command !== want.cmd)
      report($sformatf("command: expected %0d got %0d", want.cmd, out_command));
    if (out_command_report !== want.rep)
      report($sformatf("command_report: expected %02h got %02h", want.rep, out_command_report));
    if (out_snap_ready !== want.ready)
      report($sformatf("snap_ready: expected %0b got %0b", want.ready, out_snap_ready));
    if (out_last !== want.last)
      report($sformatf("last: expected %0b got %0b", want.last, out_last));
  endtask

  always @(posedge clk) begin
    item_t ev;
    if (!rst_n) begin
      clear_seq();
      regs.pace_interval_us = PACE_RST;
      regs.unlock_wait_us   = UNLOCK_WAIT_RST;
      regs.resend_delay_us  = RESEND_RST;
      regs.poll_base_us     = POLL_BASE_RST;
      regs.poll_step_us     = POLL_STEP_RST;
      regs.refetch_delay_us = REFETCH_RST;
      due_cmds.delete();
    end else begin
      if (cfg_valid && cfg_ready) set_reg(cfg_idx_t'(cfg_index), cfg_data);
      if (out_valid && out_ready) check_beat();
      if (in_valid && in_ready) begin
        ev.action          = action_t'(in_action);
        ev.now_us          = in_now_us;
        ev.connected       = in_connected;
        ev.firmware_cached = in_firmware_cached;
        ev.write_id        = in_write_id;
        predict_step(ev);
      end
    end
    n_due <= due_cmds.size();
  end

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import tfs_pkg::*;

  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned SQUEEZE_CYCLES = 300;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  action_t     in_action = ACT_TICK;
  logic [31:0] in_now_us = 32'd0;
  logic        in_connected = 1'b0;
  logic        in_firmware_cached = 1'b0;
  logic [7:0]  in_write_id = 8'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_command;
  logic [7:0]  out_command_report;
  logic        out_snap_ready;
  logic        out_last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  cfg_idx_t    cfg_index = REG_PACE;
  logic [31:0] cfg_data = 32'd0;
  int          fail_count;
  int          pending;

  logic [31:0] stamp_us = 32'd0;
  int unsigned rush_left = 0;

  timed_report_fetch_sequencer_core u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_action         (in_action),
    .in_now_us         (in_now_us),
    .in_connected      (in_connected),
    .in_firmware_cached(in_firmware_cached),
    .in_write_id       (in_write_id),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_command       (out_command),
    .out_command_report(out_command_report),
    .out_snap_ready    (out_snap_ready),
    .out_last          (out_last),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  tfs_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_action         (in_action),
    .in_now_us         (in_now_us),
    .in_connected      (in_connected),
    .in_firmware_cached(in_firmware_cached),
    .in_write_id       (in_write_id),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_command       (out_command),
    .out_command_report(out_command_report),
    .out_snap_ready    (out_snap_ready),
    .out_last          (out_last),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .fail_count        (fail_count),
    .pending           (pending)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic int unsigned pick_gap(input int unsigned zero_pct);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < zero_pct) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  function automatic item_t ev_of(input action_t a, input logic [31:0] t, input logic c,
                                  input logic f, input logic [7:0] r);
    item_t ev;
    ev.action          = a;
    ev.now_us          = t;
    ev.connected       = c;
    ev.firmware_cached = f;
    ev.write_id        = r;
    return ev;
  endfunction

  task automatic send_beat(input item_t ev);
    int unsigned gap;
    if (rush_left > 0) begin
      gap = 0;
      rush_left--;
    end else begin
      gap = pick_gap(55);
      if ($urandom_range(0, 99) < 3) rush_left = $urandom_range(10, 40);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_action          <= ev.action;
    in_now_us          <= ev.now_us;
    in_connected       <= ev.connected;
    in_firmware_cached <= ev.firmware_cached;
    in_write_id        <= ev.write_id;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic put_reg(input cfg_idx_t idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic new_setting(input cfg_regs_t c);
    drain();
    put_reg(REG_PACE, c.pace_interval_us);
    put_reg(REG_UNLOCK_WAIT, c.unlock_wait_us);
    put_reg(REG_RESEND, c.resend_delay_us);
    put_reg(REG_POLL_BASE, c.poll_base_us);
    put_reg(REG_POLL_STEP, c.poll_step_us);
    put_reg(REG_REFETCH, c.refetch_delay_us);
    cfg_valid <= 1'b0;
  endtask

  // mostly ticks on a live link, with save writes and attaches to drive the chains
  task automatic next_event(input int unsigned step_max, output item_t ev);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if ($urandom_range(0, 99) < 3) stamp_us = $urandom;
    else stamp_us = stamp_us + $urandom_range(0, step_max);
    ev.now_us          = stamp_us;
    ev.connected       = ($urandom_range(0, 99) < 96);
    ev.firmware_cached = 1'($urandom_range(0, 1));
    ev.write_id        = 8'($urandom_range(0, 255));
    if (roll < 74) begin
      ev.action = ACT_TICK;
    end else if (roll < 80) begin
      ev.action = ACT_ATTACH;
    end else if (roll < 97) begin
      ev.action = ACT_WRITE;
      if ($urandom_range(0, 99) < 80)
        ev.write_id = 8'($urandom_range(SAVE_ID_LO, SAVE_ID_HI));
    end else begin
      ev.action = ACT_SOFT_RST;
    end
  endtask

  task automatic random_beats(input int count, input int unsigned step_max);
    item_t ev;
    repeat (count) begin
      next_event(step_max, ev);
      send_beat(ev);
    end
  endtask

  // result sink: random stalls, plus two long hold-offs to back the block up
  initial begin
    int unsigned burst;
    int unsigned hold;
    int unsigned rounds;
    rounds = 0;
    while (!rst_n) @(posedge clk);
    forever begin
      rounds++;
      burst = ($urandom_range(0, 99) < 8) ? $urandom_range(40, 80) : $urandom_range(1, 16);
      if (rounds == 60 || rounds == 250) hold = SQUEEZE_CYCLES;
      else hold = pick_gap(30);
      out_ready <= 1'b1;
      repeat (burst) @(posedge clk);
      if (hold > 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
    end
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("tb_top: FAIL");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset register values
    send_beat(ev_of(ACT_TICK, 32'd0, 1'b1, 1'b0, 8'h00));
    send_beat(ev_of(ACT_ATTACH, 32'd100, 1'b1, 1'b1, 8'h00));
    send_beat(ev_of(ACT_ATTACH, 32'd200, 1'b1, 1'b0, 8'h00));
    send_beat(ev_of(ACT_WRITE, 32'd300, 1'b1, 1'b0, SAVE_ID_LO - 8'd1));
    send_beat(ev_of(ACT_WRITE, 32'd300, 1'b1, 1'b0, SAVE_ID_HI + 8'd1));
    send_beat(ev_of(ACT_WRITE, 32'd1000, 1'b1, 1'b0, SAVE_ID_HI));
    send_beat(ev_of(ACT_WRITE, 32'd1000, 1'b1, 1'b0, SAVE_ID_LO));
    send_beat(ev_of(ACT_TICK, 32'd501000, 1'b1, 1'b0, 8'h00));
    send_beat(ev_of(ACT_TICK, 32'd1001000, 1'b1, 1'b0, 8'h00));
    send_beat(ev_of(ACT_TICK, 32'd4000200, 1'b1, 1'b0, 8'h00));
    send_beat(ev_of(ACT_TICK, 32'd4080000, 1'b1, 1'b0, 8'h00));
    send_beat(ev_of(ACT_TICK, 32'd4160000, 1'b1, 1'b0, 8'h00));
    send_beat(ev_of(ACT_TICK, 32'd4240000, 1'b1, 1'b0, 8'h00));
    send_beat(ev_of(ACT_TICK, 32'd4320000, 1'b1, 1'b0, 8'h00));
    // refetch restarts the prefetch and drops the pending ready mark
    send_beat(ev_of(ACT_TICK, 32'd5501000, 1'b1, 1'b0, 8'h00));
    send_beat(ev_of(ACT_TICK, 32'd5501000, 1'b1, 1'b0, 8'h00));
    send_beat(ev_of(ACT_TICK, 32'd5600000, 1'b0, 1'b0, 8'h00));
    // wrap across zero, then lose the link in the post-save and unlock sub-sequencers
    send_beat(ev_of(ACT_ATTACH, 32'hFFFF_FF00, 1'b1, 1'b1, 8'hFF));
    send_beat(ev_of(ACT_WRITE, 32'hFFFF_FF00, 1'b1, 1'b1, SAVE_ID_HI - 8'd1));
    send_beat(ev_of(ACT_TICK, 32'h0007_A000, 1'b0, 1'b1, 8'hFF));
    send_beat(ev_of(ACT_TICK, 32'h0000_0100, 1'b0, 1'b1, 8'hFF));
    send_beat(ev_of(ACT_ATTACH, 32'd5, 1'b1, 1'b0, 8'h00));
    send_beat(ev_of(ACT_SOFT_RST, 32'hFFFF_FFFF, 1'b1, 1'b1, 8'hFF));
    send_beat(ev_of(ACT_TICK, 32'hFFFF_FFFF, 1'b1, 1'b1, 8'hFF));

    new_setting('{32'd10, 32'd40, 32'd15, 32'd25, 32'd6, 32'd90});
    random_beats(250, 20);

    new_setting('{32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0});
    random_beats(120, 3);

    new_setting('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
    // elapsed time of exactly all ones meets a maximal threshold
    send_beat(ev_of(ACT_ATTACH, 32'h1234_5678, 1'b1, 1'b0, 8'h00));
    send_beat(ev_of(ACT_WRITE, 32'h1234_5678, 1'b1, 1'b0, SAVE_ID_LO));
    send_beat(ev_of(ACT_TICK, 32'h1234_5677, 1'b1, 1'b0, 8'h00));
    stamp_us = 32'h1234_5677;
    random_beats(60, 1000);

    // negative poll step: thresholds count down
    new_setting('{32'd3, 32'd30, 32'd2, 32'd60, 32'hFFFF_FFF6, 32'd70});
    random_beats(150, 12);

    new_setting('{32'($urandom_range(0, 20)), 32'($urandom_range(0, 150)),
                  32'($urandom_range(0, 60)), 32'($urandom_range(0, 80)),
                  32'($urandom_range(0, 30)), 32'($urandom_range(0, 250))});
    random_beats(200, 30);

    new_setting('{PACE_RST, UNLOCK_WAIT_RST, RESEND_RST, POLL_BASE_RST, POLL_STEP_RST,
                  REFETCH_RST});
    random_beats(120, 300000);

    drain();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("tb_top: PASS");
    else
      $display("tb_top: FAIL");
    $finish;
  end

endmodule
